[hw/rtl/gqfn_pkg.sv]
package gqfn_pkg;

    // Field and datapath widths
    localparam int HW           = 16;   // input height, Q11.4
    localparam int SPW          = 10;   // cell spacing register
    localparam int DW           = 17;   // corner height difference
    localparam int CW           = 18;   // cross product component
    localparam int MW           = 17;   // component magnitude
    localparam int SQW          = 2 * MW;
    localparam int NW           = SQW + 2;  // squared length of a vector
    localparam int FRAC_SHIFT   = 30;   // (2 * 16384)^2
    localparam int EW           = SQW + FRAC_SHIFT;
    localparam int AW           = NW + FRAC_SHIFT + 2;
    localparam int RW           = 16;   // root of the scaled ratio
    localparam int QW           = 16;   // output component, Q1.14
    localparam int FRONT_STAGES = 3;
    localparam int ROOT_STAGES  = RW;
    localparam int NUM_STAGES   = FRONT_STAGES + ROOT_STAGES + 1;
    localparam int NUM_COMP     = 6;

    // One component under square root search
    typedef struct packed {
        logic [AW-1:0] b;   // running root times length, aligned to the current bit
        logic [EW-1:0] e;   // remainder of the scaled square
        logic [RW-1:0] r;   // root bits found so far
    } lane_t;

    // One triangle normal: shared length term and three components
    typedef struct packed {
        logic [AW-1:0]  a;
        lane_t [2:0]    lane;
    } vec_t;

    // Everything one item carries through the root stages
    typedef struct packed {
        vec_t [1:0]             vec;
        logic [NUM_COMP-1:0]    neg;
        logic                   zero;
    } root_t;

endpackage

[hw/rtl/gqfn_front.sv]
module gqfn_front
    import gqfn_pkg::*;
(
    input  logic                    aclk,
    input  logic [FRONT_STAGES-1:0] en,
    input  logic [SPW-1:0]          spacing,
    input  logic [HW-1:0]           height_base,
    input  logic [HW-1:0]           height_next_row,
    input  logic [HW-1:0]           height_diagonal,
    input  logic [HW-1:0]           height_next_col,
    output root_t                   root_out
);

    logic signed [DW-1:0] diff_a, diff_b, diff_c;
    logic signed [CW-1:0] comp_next [NUM_COMP];
    logic signed [CW-1:0] comp_reg  [NUM_COMP];
    logic                 zero1_reg;

    logic [MW-1:0]        mag       [NUM_COMP];
    logic [SQW-1:0]       sq_next   [NUM_COMP];
    logic [SQW-1:0]       sq_reg    [NUM_COMP];
    logic [NUM_COMP-1:0]  neg_next;
    logic [NUM_COMP-1:0]  neg2_reg;
    logic                 zero2_reg;

    logic [NW-1:0]        norm_next [2];
    root_t                root_next;
    root_t                root_reg;

    // Edge differences and the scaled cross products
    always_comb begin
        diff_a = {height_next_row[HW-1], height_next_row} - {height_base[HW-1], height_base};
        diff_b = {height_diagonal[HW-1], height_diagonal} - {height_base[HW-1], height_base};
        diff_c = {height_next_col[HW-1], height_next_col} - {height_base[HW-1], height_base};
        comp_next[0] = {diff_a[DW-1], diff_a} - {diff_b[DW-1], diff_b};
        comp_next[1] = {{(CW-SPW-4){1'b0}}, spacing, 4'b0000};
        comp_next[2] = -{diff_a[DW-1], diff_a};
        comp_next[3] = -{diff_c[DW-1], diff_c};
        comp_next[4] = {{(CW-SPW-4){1'b0}}, spacing, 4'b0000};
        comp_next[5] = {diff_c[DW-1], diff_c} - {diff_b[DW-1], diff_b};
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            comp_reg  <= comp_next;
            zero1_reg <= (spacing == '0);
        end
    end

    // Magnitudes and squares
    always_comb begin
        for (int i = 0; i < NUM_COMP; i++) begin
            neg_next[i] = comp_reg[i][CW-1];
            if (comp_reg[i][CW-1]) begin
                mag[i] = MW'(-comp_reg[i]);
            end else begin
                mag[i] = MW'(comp_reg[i]);
            end
            sq_next[i] = mag[i] * mag[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            sq_reg    <= sq_next;
            neg2_reg  <= neg_next;
            zero2_reg <= zero1_reg;
        end
    end

    // Squared lengths and the start values of the root search
    always_comb begin
        root_next = '0;
        for (int v = 0; v < 2; v++) begin
            norm_next[v] = NW'(sq_reg[3*v]) + NW'(sq_reg[3*v+1]) + NW'(sq_reg[3*v+2]);
            root_next.vec[v].a = AW'(norm_next[v]) << FRAC_SHIFT;
            for (int l = 0; l < 3; l++) begin
                root_next.vec[v].lane[l].e = EW'(sq_reg[3*v+l]) << FRAC_SHIFT;
            end
        end
        root_next.neg  = neg2_reg;
        root_next.zero = zero2_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            root_reg <= root_next;
        end
    end

    assign root_out = root_reg;

endmodule

[hw/rtl/gqfn_root_stage.sv]
module gqfn_root_stage
    import gqfn_pkg::*;
(
    input  logic  aclk,
    input  logic  en,
    input  root_t root_in,
    output root_t root_out
);

    logic [AW-1:0] trial [2][3];
    logic          fits  [2][3];
    logic [AW-1:0] b_upd [2][3];
    root_t         root_next;
    root_t         root_reg;

    // Decide one root bit per component and realign for the next bit
    always_comb begin
        root_next      = root_in;
        for (int v = 0; v < 2; v++) begin
            root_next.vec[v].a = root_in.vec[v].a >> 2;
            for (int l = 0; l < 3; l++) begin
                trial[v][l] = root_in.vec[v].lane[l].b + root_in.vec[v].a;
                fits[v][l]  = trial[v][l] <= AW'(root_in.vec[v].lane[l].e);
                if (fits[v][l]) begin
                    b_upd[v][l] = root_in.vec[v].lane[l].b + (root_in.vec[v].a << 1);
                    root_next.vec[v].lane[l].e =
                        root_in.vec[v].lane[l].e - trial[v][l][EW-1:0];
                end else begin
                    b_upd[v][l] = root_in.vec[v].lane[l].b;
                    root_next.vec[v].lane[l].e = root_in.vec[v].lane[l].e;
                end
                root_next.vec[v].lane[l].b = b_upd[v][l] >> 1;
                root_next.vec[v].lane[l].r = {root_in.vec[v].lane[l].r[RW-2:0], fits[v][l]};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            root_reg <= root_next;
        end
    end

    assign root_out = root_reg;

endmodule

[hw/rtl/grid_quad_face_normals_top.sv]
// Pipeline: 3 front, 16 root and 1 output stage from input transaction to result.
// Throughput: one transaction per cycle unless the output stalls; each stage holds one item
// and moves when the next stage is empty or moving, so input blocks only once all are full.
// Reset: aresetn is synchronous, active low; it clears all valid bits and sets
// spacing_reg to 1. Datapath registers are not reset.
module grid_quad_face_normals_top
    import gqfn_pkg::*;
(
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_wr_en,
    input  logic [SPW-1:0] cfg_wr_data,
    input  logic           s_tvalid,
    output logic           s_tready,
    // height_base, height_next_row, height_diagonal, height_next_col
    input  logic [63:0]    s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    // first_normal_x, first_normal_y, first_normal_z,
    // second_normal_x, second_normal_y, second_normal_z
    output logic [95:0]    m_tdata
);

    logic [SPW-1:0]        spacing_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] en;
    root_t                 root_chain [ROOT_STAGES+1];
    logic [RW:0]           r_inc      [NUM_COMP];
    logic [QW-1:0]         q_mag      [NUM_COMP];
    logic [QW-1:0]         out_next   [NUM_COMP];
    logic [QW-1:0]         out_reg    [NUM_COMP];

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spacing_reg <= SPW'(1);
        end else if (cfg_wr_en) begin
            spacing_reg <= cfg_wr_data;
        end
    end

    // Stage enables: a stage moves when it is empty or its successor moves
    always_comb begin
        en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
    end

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign s_tready = en[0];

    gqfn_front u_front (
        .aclk            (aclk),
        .en              (en[FRONT_STAGES-1:0]),
        .spacing         (spacing_reg),
        .height_base     (s_tdata[15:0]),
        .height_next_row (s_tdata[31:16]),
        .height_diagonal (s_tdata[47:32]),
        .height_next_col (s_tdata[63:48]),
        .root_out        (root_chain[0])
    );

    for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_root
        gqfn_root_stage u_stage (
            .aclk     (aclk),
            .en       (en[FRONT_STAGES+k]),
            .root_in  (root_chain[k]),
            .root_out (root_chain[k+1])
        );
    end

    // Round the root to the output scale, restore sign, force zero spacing to zero
    always_comb begin
        for (int i = 0; i < NUM_COMP; i++) begin
            r_inc[i] = {1'b0, root_chain[ROOT_STAGES].vec[i/3].lane[i%3].r} + (RW+1)'(1);
            q_mag[i] = r_inc[i][RW:1];
            if (root_chain[ROOT_STAGES].zero) begin
                out_next[i] = '0;
            end else if (root_chain[ROOT_STAGES].neg[i]) begin
                out_next[i] = -q_mag[i];
            end else begin
                out_next[i] = q_mag[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[NUM_STAGES-1]) begin
            out_reg <= out_next;
        end
    end

    assign m_tvalid = valid_reg[NUM_STAGES-1];
    assign m_tdata  = {out_reg[5], out_reg[4], out_reg[3], out_reg[2], out_reg[1], out_reg[0]};

`ifndef ASSERT_OFF
    // Input side is open whenever the output register is empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output stage");

    // Vertical components never point down
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[31] && !m_tdata[79])
        else $error("negative normal y component");

    // The x and z components stay within unit range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata[15:0]) <= 16384 && $signed(m_tdata[15:0]) >= -16384
            && $signed(m_tdata[47:32]) <= 16384 && $signed(m_tdata[47:32]) >= -16384
            && $signed(m_tdata[63:48]) <= 16384 && $signed(m_tdata[63:48]) >= -16384
            && $signed(m_tdata[95:80]) <= 16384 && $signed(m_tdata[95:80]) >= -16384))
        else $error("normal component out of range");

    // An accepted transaction enters the first stage as valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> valid_reg[0])
        else $error("accepted transaction lost at entry");
`endif

endmodule
